>>> sv/btd_pkg.sv
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types, constants and codes for the battery charge trend detector.
// ----------------------------------------------------------------------------
package btd_pkg;

  // default sizes handed to the top level
  localparam int RING_DEPTH_DEF = 12;
  localparam int MIN_FILL_DEF   = 6;

  // field widths
  localparam int VOLT_W   = 13;
  localparam int MV_W     = 14;
  localparam int PCT_W    = 8;
  localparam int THR_W    = 10;
  localparam int WAIT_W   = 16;
  localparam int TALLY_W  = 32;
  localparam int CODE_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // value limits
  localparam logic [VOLT_W-1:0] MV_MAX  = VOLT_W'(5000);
  localparam logic [PCT_W-1:0]  PCT_MAX = PCT_W'(100);

  // register reset values
  localparam logic [THR_W-1:0]  THR_RST    = THR_W'(15);
  localparam logic [VOLT_W-1:0] FULL_RST   = VOLT_W'(4180);
  localparam logic [WAIT_W-1:0] ACTIVE_RST = WAIT_W'(5000);
  localparam logic [WAIT_W-1:0] IDLE_RST   = WAIT_W'(15000);
  localparam logic [WAIT_W-1:0] ABSENT_RST = WAIT_W'(30000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TREND_THRESHOLD = 3'd0,
    REG_FULL_LEVEL      = 3'd1,
    REG_ACTIVE_WAIT     = 3'd2,
    REG_IDLE_WAIT       = 3'd3,
    REG_ABSENT_WAIT     = 3'd4
  } cfg_reg_t;

  // trend codes
  typedef enum logic [1:0] {
    TREND_UNKNOWN     = 2'd0,
    TREND_CHARGING    = 2'd1,
    TREND_DISCHARGING = 2'd2
  } trend_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_AVG,
    ST_DECIDE,
    ST_DONE
  } seq_state_t;

  // ring control from the sequencer
  typedef struct packed {
    logic store;
    logic rd_start;
    logic rd_en;
  } ring_ctrl_t;

endpackage

>>> sv/btd_poll_if.sv
// ----------------------------------------------------------------------------
// btd_poll_if
// Poll channel: one fuel-gauge poll per transfer.
// ----------------------------------------------------------------------------
interface btd_poll_if;
  logic                          valid;
  logic                          ready;
  logic                          gauge_answered;
  logic [btd_pkg::CODE_W-1:0]    charge_code;
  logic [btd_pkg::CODE_W-1:0]    cell_code;

  modport source (output valid, gauge_answered, charge_code, cell_code, input ready);
  modport sink (input valid, gauge_answered, charge_code, cell_code, output ready);
endinterface

>>> sv/btd_result_if.sv
// ----------------------------------------------------------------------------
// btd_result_if
// Result channel: one report per poll.
// ----------------------------------------------------------------------------
interface btd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              battery_present;
  logic signed [btd_pkg::PCT_W-1:0]  charge_percent;
  logic signed [btd_pkg::MV_W-1:0]   cell_mv;
  logic [1:0]                        trend_state;
  logic [btd_pkg::WAIT_W-1:0]        next_wait_ms;
  logic [btd_pkg::TALLY_W-1:0]       good_polls;

  modport source (output valid, battery_present, charge_percent, cell_mv, trend_state,
                  next_wait_ms, good_polls, input ready);
  modport sink (input valid, battery_present, charge_percent, cell_mv, trend_state,
                next_wait_ms, good_polls, output ready);
endinterface

>>> sv/btd_ring.sv
// ----------------------------------------------------------------------------
// btd_ring
// Voltage sample ring: write pointer, fill count, and a read walker that
// steps from the newest sample backward with registered read data.
// ----------------------------------------------------------------------------
module btd_ring #(
  parameter int  DEPTH  = btd_pkg::RING_DEPTH_DEF,
  localparam int PTR_W  = $clog2(DEPTH),
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  btd_pkg::ring_ctrl_t           ctrl,
  input  logic [btd_pkg::VOLT_W-1:0]    wr_data,
  output logic [FILL_W-1:0]             fill,
  output logic [btd_pkg::VOLT_W-1:0]    rd_data
);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

  logic [btd_pkg::VOLT_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]           wr_pos;
  logic [PTR_W-1:0]           rd_ptr;

  // write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      fill   <= '0;
    end else if (ctrl.store) begin
      wr_pos <= (wr_pos == PTR_LAST) ? '0 : wr_pos + PTR_W'(1);
      if (fill != FILL_FULL) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  // sample storage
  always_ff @(posedge clk) begin
    if (ctrl.store) begin
      mem[wr_pos] <= wr_data;
    end
  end

  // backward read walker, starts at the newest sample
  always_ff @(posedge clk) begin
    if (ctrl.rd_start) begin
      rd_ptr <= (wr_pos == '0) ? PTR_LAST : wr_pos - PTR_W'(1);
    end else if (ctrl.rd_en) begin
      rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - PTR_W'(1);
    end
  end

  // registered read data
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

>>> sv/battery_charge_trend_detector_unit.sv
// ----------------------------------------------------------------------------
// battery_charge_trend_detector_unit
// Per-poll report of charge percent and cell voltage, a voltage trend taken
// from the sample ring, the next poll interval and a count of answered polls.
// ----------------------------------------------------------------------------
// sequence: an absent poll goes straight to the result; an answered poll
//   stores its sample and checks the fill, and with enough samples it sums and
//   divides the newest half, then the older half, and then decides the trend
// throughput: one poll at a time; set by the single shared adder/subtractor
//   that sums the ring one sample a cycle and divides one quotient bit a cycle
// reset: synchronous rst clears control, the poll tally and the ring write
//   pointer and fill count and loads the register defaults; the ring needs no clearing pass
module battery_charge_trend_detector_unit #(
  parameter int RING_DEPTH = btd_pkg::RING_DEPTH_DEF,
  parameter int MIN_FILL   = btd_pkg::MIN_FILL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [btd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btd_pkg::CFG_W-1:0]         cfg_data,
  btd_poll_if.sink                          poll,
  btd_result_if.source                      result
);

  localparam int VOLT_W  = btd_pkg::VOLT_W;
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int HALF_W  = $clog2(RING_DEPTH / 2 + 1);
  localparam int SUM_W   = VOLT_W + HALF_W;
  localparam int ALU_W   = SUM_W + 1;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int DELTA_W = VOLT_W + 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  // configuration registers
  logic [btd_pkg::THR_W-1:0]  trend_threshold_mv;
  logic [VOLT_W-1:0]          full_level_mv;
  logic [btd_pkg::WAIT_W-1:0] active_wait_ms;
  logic [btd_pkg::WAIT_W-1:0] idle_wait_ms;
  logic [btd_pkg::WAIT_W-1:0] absent_wait_ms;

  // sequencer and datapath registers
  btd_pkg::seq_state_t        state, state_next;
  logic                       answered;
  logic [btd_pkg::PCT_W-1:0]  percent;
  logic [VOLT_W-1:0]          mv;
  logic [HALF_W-1:0]          half;
  logic [HALF_W-1:0]          cnt;
  logic                       rd_pend;
  logic                       phase;
  logic [SUM_W-1:0]           acc;
  logic [SUM_W-1:0]           quo;
  logic [HALF_W-1:0]          rem;
  logic [STEP_W-1:0]          step;
  logic [VOLT_W-1:0]          avg_a;
  logic [VOLT_W-1:0]          avg_b;
  btd_pkg::trend_t            trend;
  logic [btd_pkg::TALLY_W-1:0] tally;

  // output register
  logic                              out_valid;
  logic                              out_present;
  logic [btd_pkg::PCT_W-1:0]         out_percent;
  logic [btd_pkg::MV_W-1:0]          out_mv;
  logic [1:0]                        out_trend;
  logic [btd_pkg::WAIT_W-1:0]        out_wait;
  logic [btd_pkg::TALLY_W-1:0]       out_tally;

  // control and shared unit
  logic                       in_xfer;
  logic                       out_free;
  logic                       load_out;
  btd_pkg::ring_ctrl_t        ring_ctrl;
  logic [FILL_W-1:0]          fill;
  logic [VOLT_W-1:0]          rd_data;
  logic [ALU_W-1:0]           alu_x;
  logic [ALU_W-1:0]           alu_y;
  logic                       alu_sub;
  logic [ALU_W-1:0]           alu_res;
  logic                       alu_neg;

  // decode of the incoming poll
  logic [14:0]                mv_x5;
  logic [VOLT_W-1:0]          mv_in;
  logic [btd_pkg::PCT_W-1:0]  pct_raw;
  logic [btd_pkg::PCT_W-1:0]  pct_in;
  logic                       in_window;
  logic                       few_samples;
  logic [HALF_W-1:0]          half_new;
  logic [HALF_W:0]            rem_shift;

  // trend decision
  logic signed [DELTA_W-1:0]  delta;
  logic signed [DELTA_W-1:0]  thr_pos;
  logic signed [DELTA_W-1:0]  thr_neg;
  btd_pkg::trend_t            trend_new;
  logic [btd_pkg::WAIT_W-1:0] wait_sel;
  logic [btd_pkg::TALLY_W-1:0] tally_new;

  btd_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ring_ctrl),
    .wr_data (mv),
    .fill    (fill),
    .rd_data (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trend_threshold_mv <= btd_pkg::THR_RST;
      full_level_mv      <= btd_pkg::FULL_RST;
      active_wait_ms     <= btd_pkg::ACTIVE_RST;
      idle_wait_ms       <= btd_pkg::IDLE_RST;
      absent_wait_ms     <= btd_pkg::ABSENT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        btd_pkg::REG_TREND_THRESHOLD: trend_threshold_mv <= cfg_data[btd_pkg::THR_W-1:0];
        btd_pkg::REG_FULL_LEVEL:      full_level_mv      <= cfg_data[VOLT_W-1:0];
        btd_pkg::REG_ACTIVE_WAIT:     active_wait_ms     <= cfg_data;
        btd_pkg::REG_IDLE_WAIT:       idle_wait_ms       <= cfg_data;
        btd_pkg::REG_ABSENT_WAIT:     absent_wait_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // poll decode: mv = code12 * 5 / 4, percent clamped
  assign mv_x5     = {1'b0, poll.cell_code[15:4], 2'b00} + {3'b000, poll.cell_code[15:4]};
  assign mv_in     = mv_x5[14:2];
  assign pct_raw   = poll.charge_code[15:8];
  assign pct_in    = (pct_raw > btd_pkg::PCT_MAX) ? btd_pkg::PCT_MAX : pct_raw;
  assign in_window = (mv != '0) && (mv <= btd_pkg::MV_MAX);

  // sample count check after the store
  assign few_samples = (32'(fill) < 32'(MIN_FILL));
  assign half_new    = HALF_W'(fill >> 1);

  // shared adder/subtractor
  assign alu_res = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);
  assign alu_neg = alu_res[ALU_W-1];

  // divider trial operand: remainder with next dividend bit
  assign rem_shift = {rem, quo[SUM_W-1]};

  // trend decision from the two averages
  assign delta   = alu_res[DELTA_W-1:0];
  assign thr_pos = {{(DELTA_W - btd_pkg::THR_W){1'b0}}, trend_threshold_mv};
  assign thr_neg = -thr_pos;

  always_comb begin
    if ((avg_a >= full_level_mv) && (delta >= 0)) begin
      trend_new = btd_pkg::TREND_UNKNOWN;
    end else if (delta >= thr_pos) begin
      trend_new = btd_pkg::TREND_CHARGING;
    end else if (delta <= thr_neg) begin
      trend_new = btd_pkg::TREND_DISCHARGING;
    end else begin
      trend_new = btd_pkg::TREND_UNKNOWN;
    end
  end

  // interval and tally for the result
  always_comb begin
    if (!answered) begin
      wait_sel = absent_wait_ms;
    end else if ((32'(fill) >= 32'(RING_DEPTH)) && (trend != btd_pkg::TREND_CHARGING)) begin
      wait_sel = idle_wait_ms;
    end else begin
      wait_sel = active_wait_ms;
    end
  end
  assign tally_new = answered ? tally + btd_pkg::TALLY_W'(1) : tally;

  assign out_free = !out_valid || result.ready;
  assign in_xfer  = poll.valid && poll.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      btd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = poll.gauge_answered ? btd_pkg::ST_STORE : btd_pkg::ST_DONE;
        end
      end
      btd_pkg::ST_STORE: state_next = btd_pkg::ST_CHECK;
      btd_pkg::ST_CHECK: begin
        state_next = (few_samples || half_new == '0) ? btd_pkg::ST_DONE : btd_pkg::ST_SUM;
      end
      btd_pkg::ST_SUM: begin
        if (cnt == half && !rd_pend) begin
          state_next = btd_pkg::ST_DIV;
        end
      end
      btd_pkg::ST_DIV: begin
        if (step == STEP_LAST) begin
          state_next = btd_pkg::ST_AVG;
        end
      end
      btd_pkg::ST_AVG:    state_next = phase ? btd_pkg::ST_DECIDE : btd_pkg::ST_SUM;
      btd_pkg::ST_DECIDE: state_next = btd_pkg::ST_DONE;
      btd_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = btd_pkg::ST_IDLE;
        end
      end
      default: state_next = btd_pkg::ST_IDLE;
    endcase
  end

  // control outputs and shared unit operands
  always_comb begin
    poll.ready         = 1'b0;
    ring_ctrl.store    = 1'b0;
    ring_ctrl.rd_start = 1'b0;
    ring_ctrl.rd_en    = 1'b0;
    load_out           = 1'b0;
    alu_x              = '0;
    alu_y              = '0;
    alu_sub            = 1'b0;
    case (state)
      btd_pkg::ST_IDLE:  poll.ready = 1'b1;
      btd_pkg::ST_STORE: ring_ctrl.store = in_window;
      btd_pkg::ST_CHECK: ring_ctrl.rd_start = 1'b1;
      btd_pkg::ST_SUM: begin
        ring_ctrl.rd_en = (cnt != half);
        alu_x           = ALU_W'(acc);
        alu_y           = ALU_W'(rd_data);
      end
      btd_pkg::ST_DIV: begin
        alu_x   = ALU_W'(rem_shift);
        alu_y   = ALU_W'(half);
        alu_sub = 1'b1;
      end
      btd_pkg::ST_DECIDE: begin
        alu_x   = ALU_W'(avg_a);
        alu_y   = ALU_W'(avg_b);
        alu_sub = 1'b1;
      end
      btd_pkg::ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // poll tally
  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (load_out) begin
      tally <= tally_new;
    end
  end

  // read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= ring_ctrl.rd_en;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      btd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          answered <= poll.gauge_answered;
          percent  <= pct_in;
          mv       <= mv_in;
          trend    <= btd_pkg::TREND_UNKNOWN;
        end
      end
      btd_pkg::ST_CHECK: begin
        half  <= half_new;
        cnt   <= '0;
        acc   <= '0;
        phase <= 1'b0;
      end
      btd_pkg::ST_SUM: begin
        if (ring_ctrl.rd_en) begin
          cnt <= cnt + HALF_W'(1);
        end
        if (rd_pend) begin
          acc <= alu_res[SUM_W-1:0];
        end
        if (cnt == half && !rd_pend) begin
          quo  <= acc;
          rem  <= '0;
          step <= '0;
        end
      end
      btd_pkg::ST_DIV: begin
        // restoring division, one quotient bit a cycle
        step <= step + STEP_W'(1);
        if (!alu_neg) begin
          rem <= alu_res[HALF_W-1:0];
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift[HALF_W-1:0];
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
      end
      btd_pkg::ST_AVG: begin
        if (phase) begin
          avg_b <= quo[VOLT_W-1:0];
        end else begin
          avg_a <= quo[VOLT_W-1:0];
          acc   <= '0;
          cnt   <= '0;
          phase <= 1'b1;
        end
      end
      btd_pkg::ST_DECIDE: trend <= trend_new;
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_present <= answered;
      out_percent <= answered ? percent : '1;
      out_mv      <= answered ? {1'b0, mv} : '1;
      out_trend   <= trend;
      out_wait    <= wait_sel;
      out_tally   <= tally_new;
    end
  end

  assign result.valid           = out_valid;
  assign result.battery_present = out_present;
  assign result.charge_percent  = out_percent;
  assign result.cell_mv         = out_mv;
  assign result.trend_state     = out_trend;
  assign result.next_wait_ms    = out_wait;
  assign result.good_polls      = out_tally;

endmodule
